FILE: rtl/core/algtc_pkg.sv
// Package: constants, types and codes for the adaptive LRU glyph tag cache.
`default_nettype none

package algtc_pkg;

   localparam int MAX_ENTRIES_DEF  = 256;
   localparam int INIT_ENTRIES_RST = 120;
   localparam int GROW_STEP_RST    = 32;
   localparam int WIN_SHIFT_RST    = 4;

   localparam int KEY_W   = 32;
   localparam int STAMP_W = 32;
   localparam int COUNT_W = 32;
   localparam int CFG_W   = 9;
   localparam int SHIFT_W = 4;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_ENTRIES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GROW_STEP       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SHIFT    = 2'd2;

   typedef struct packed {
      logic [KEY_W-1:0] face_id;
      logic [KEY_W-1:0] scale_bits;
      logic [KEY_W-1:0] height_bits;
      logic [KEY_W-1:0] char_code;
   } key_type;

   typedef struct packed {
      logic [STAMP_W-1:0] stamp;
      key_type            key;
   } row_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clr_all;
   } store_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_HIT,
      ST_WIN,
      ST_RATIO,
      ST_FILL
   } state_type;

endpackage

`default_nettype wire

FILE: rtl/core/adaptive_lru_glyph_tag_cache_unit.sv
// Top level: fully associative glyph tag cache with LRU stamps and adaptive size.
//
//   channel | direction | handshake               | payload
//   req     | in        | req_tvalid/req_tready   | req_tdata: four 32-bit key parts
//   rsp     | out       | rsp_tvalid/rsp_tready   | rsp_tdata, rsp_tuser: hit flag
//   csr     | in        | csr_valid/csr_ready     | csr_index, csr_data
//
// One entry of the tag memory is read and compared per cycle, from the top entry down.
// A hit ends the scan and registers its result in ST_HIT; a miss scans every active entry,
// goes through ST_WIN and ST_RATIO and registers it in ST_FILL. The next item waits for that.
// A result waits in the output register; the next item is accepted meanwhile and is
// held before its own result if the register is still full. A csr write wins over an item.
// Reset is synchronous and clears counters and valid flags and restores the size.
`default_nettype none

module adaptive_lru_glyph_tag_cache_unit
   import algtc_pkg::*;
#(
   parameter int MaxEntries = MAX_ENTRIES_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [127:0]         req_tdata,  // char_code, height_bits, scale_bits, face_id
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [23:0]               rsp_tdata,  // entry_index, grew, active_entries, zero pad
   output logic                      rsp_tuser,  // hit
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_data
);

   localparam int IW = $clog2(MaxEntries);
   localparam int CW = $clog2(MaxEntries + 1);
   localparam int SW = ((CW > CFG_W) ? CW : CFG_W) + 1;
   localparam int OW = ((CW + 16) > (COUNT_W + 1)) ? (CW + 16) : (COUNT_W + 1);
   localparam int ActRst = (INIT_ENTRIES_RST > MaxEntries) ? MaxEntries : INIT_ENTRIES_RST;

   state_type            state_ff, state_in;
   key_type              key_ff, key_in;
   logic [STAMP_W-1:0]   req_cnt_ff, req_cnt_in;
   logic [COUNT_W-1:0]   hit_cnt_ff, hit_cnt_in;
   logic [COUNT_W-1:0]   miss_cnt_ff, miss_cnt_in;
   logic [CW-1:0]        active_ff, active_in;
   logic [CFG_W-1:0]     grow_ff, grow_in;
   logic [SHIFT_W-1:0]   shift_ff, shift_in;
   logic [IW-1:0]        rd_idx_ff, rd_idx_in;
   logic                 issue_ff, issue_in;
   logic                 chk_ff, chk_in;
   logic [IW-1:0]        chk_idx_ff, chk_idx_in;
   logic                 first_ff, first_in;
   logic [STAMP_W-1:0]   best_ff, best_in;
   logic [IW-1:0]        best_idx_ff, best_idx_in;
   logic                 ovf_ff, ovf_in;
   logic                 want_grow_ff, want_grow_in;
   logic                 rsp_vld_ff, rsp_vld_in;
   logic                 rsp_hit_ff, rsp_hit_in;
   logic [7:0]           rsp_idx_ff, rsp_idx_in;
   logic                 rsp_grew_ff, rsp_grew_in;
   logic [8:0]           rsp_act_ff, rsp_act_in;

   store_ctl_type        st_ctl;
   logic [IW-1:0]        wr_addr;
   row_type              wr_row;
   row_type              rd_row;
   logic                 rd_vld;

   logic                 out_free;
   logic                 match;
   logic [STAMP_W-1:0]   stamp_cur;
   logic [SW-1:0]        grow_sum;
   logic [CW-1:0]        grown;
   logic [OW-1:0]        win_lhs;
   logic [OW-1:0]        win_rhs;
   logic [IW-1:0]        victim;
   logic                 grew_now;

   algtc_tag_store #(
      .MaxEntries (MaxEntries)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .ctl     (st_ctl),
      .rd_addr (rd_idx_ff),
      .wr_addr (wr_addr),
      .wr_data (wr_row),
      .rd_data (rd_row),
      .rd_vld  (rd_vld)
   );

   assign out_free  = !rsp_vld_ff || rsp_tready;
   assign match     = rd_vld && (rd_row.key == key_ff);
   assign stamp_cur = rd_vld ? rd_row.stamp : '0;
   assign grow_sum  = SW'(active_ff) + SW'(grow_ff);
   assign grown     = (grow_sum > SW'(MaxEntries)) ? CW'(MaxEntries) : CW'(grow_sum);
   assign win_lhs   = OW'(hit_cnt_ff) + OW'(miss_cnt_ff) + OW'(1);
   assign win_rhs   = OW'(active_ff) << shift_ff;
   assign victim    = ovf_ff ? '0 : best_idx_ff;
   assign grew_now  = want_grow_ff && (grown != active_ff);

   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      req_cnt_in   = req_cnt_ff;
      hit_cnt_in   = hit_cnt_ff;
      miss_cnt_in  = miss_cnt_ff;
      active_in    = active_ff;
      grow_in      = grow_ff;
      shift_in     = shift_ff;
      rd_idx_in    = rd_idx_ff;
      issue_in     = issue_ff;
      chk_in       = 1'b0;
      chk_idx_in   = chk_idx_ff;
      first_in     = first_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      ovf_in       = ovf_ff;
      want_grow_in = want_grow_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp_tready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_grew_in  = rsp_grew_ff;
      rsp_act_in   = rsp_act_ff;
      st_ctl       = '0;
      wr_addr      = best_idx_ff;
      wr_row.key   = key_ff;
      wr_row.stamp = req_cnt_ff;
      req_tready   = (state_ff == ST_IDLE) && !csr_valid;
      csr_ready    = (state_ff == ST_IDLE);

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_INITIAL_ENTRIES: begin
               if (csr_data == '0) begin
                  active_in = CW'(1);
               end else if (SW'(csr_data) > SW'(MaxEntries)) begin
                  active_in = CW'(MaxEntries);
               end else begin
                  active_in = CW'(csr_data);
               end
               st_ctl.clr_all = 1'b1;
               hit_cnt_in     = '0;
               miss_cnt_in    = '0;
            end
            CSR_GROW_STEP:    grow_in  = csr_data;
            CSR_WINDOW_SHIFT: shift_in = csr_data[SHIFT_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               key_in     = req_tdata;
               req_cnt_in = req_cnt_ff + 1'b1;
               rd_idx_in  = IW'(active_ff - 1'b1);
               issue_in   = 1'b1;
               first_in   = 1'b1;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            st_ctl.rd_en = issue_ff;
            chk_in       = issue_ff;
            chk_idx_in   = rd_idx_ff;
            if (issue_ff) begin
               if (rd_idx_ff == '0) begin
                  issue_in = 1'b0;
               end else begin
                  rd_idx_in = rd_idx_ff - 1'b1;
               end
            end
            if (chk_ff) begin
               if (match) begin
                  best_idx_in = chk_idx_ff;
                  issue_in    = 1'b0;
                  chk_in      = 1'b0;
                  state_in    = ST_HIT;
               end else begin
                  if (first_ff || (stamp_cur < best_ff)) begin
                     best_in     = stamp_cur;
                     best_idx_in = chk_idx_ff;
                  end
                  first_in = 1'b0;
                  if (chk_idx_ff == '0) begin
                     state_in = ST_WIN;
                  end
               end
            end
         end
         ST_HIT: begin
            if (out_free) begin
               st_ctl.wr_en = 1'b1;
               hit_cnt_in   = hit_cnt_ff + 1'b1;
               rsp_vld_in   = 1'b1;
               rsp_hit_in   = 1'b1;
               rsp_idx_in   = 8'(best_idx_ff);
               rsp_grew_in  = 1'b0;
               rsp_act_in   = 9'(active_ff);
               state_in     = ST_IDLE;
            end
         end
         ST_WIN: begin
            ovf_in      = win_lhs > win_rhs;
            miss_cnt_in = miss_cnt_ff + 1'b1;
            state_in    = ST_RATIO;
         end
         ST_RATIO: begin
            want_grow_in = ovf_ff && ({miss_cnt_ff, 1'b0} > {1'b0, hit_cnt_ff});
            state_in     = ST_FILL;
         end
         ST_FILL: begin
            if (out_free) begin
               wr_addr        = victim;
               st_ctl.wr_en   = 1'b1;
               st_ctl.clr_all = grew_now;
               if (grew_now) begin
                  active_in = grown;
               end
               if (ovf_ff) begin
                  hit_cnt_in  = '0;
                  miss_cnt_in = '0;
               end
               rsp_vld_in  = 1'b1;
               rsp_hit_in  = 1'b0;
               rsp_idx_in  = 8'(victim);
               rsp_grew_in = grew_now;
               rsp_act_in  = grew_now ? 9'(grown) : 9'(active_ff);
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_cnt_ff  <= '0;
         hit_cnt_ff  <= '0;
         miss_cnt_ff <= '0;
         active_ff   <= CW'(ActRst);
         grow_ff     <= CFG_W'(GROW_STEP_RST);
         shift_ff    <= SHIFT_W'(WIN_SHIFT_RST);
         issue_ff    <= 1'b0;
         chk_ff      <= 1'b0;
         first_ff    <= 1'b1;
         rsp_vld_ff  <= 1'b0;
      end else begin
         req_cnt_ff  <= req_cnt_in;
         hit_cnt_ff  <= hit_cnt_in;
         miss_cnt_ff <= miss_cnt_in;
         active_ff   <= active_in;
         grow_ff     <= grow_in;
         shift_ff    <= shift_in;
         issue_ff    <= issue_in;
         chk_ff      <= chk_in;
         first_ff    <= first_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      rd_idx_ff    <= rd_idx_in;
      chk_idx_ff   <= chk_idx_in;
      best_ff      <= best_in;
      best_idx_ff  <= best_idx_in;
      ovf_ff       <= ovf_in;
      want_grow_ff <= want_grow_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_grew_ff  <= rsp_grew_in;
      rsp_act_ff   <= rsp_act_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tdata  = {5'd0, rsp_act_ff, rsp_grew_ff, rsp_idx_ff};

`ifndef SYNTH
   a_active_range: assert property (@(posedge clock) disable iff (reset)
      (active_ff != '0) && (active_ff <= CW'(MaxEntries)))
      else $error("active entry count out of range");
   a_accept_scans: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_SCAN))
      else $error("accepted item did not start a scan");
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> ($past(state_ff) == ST_HIT || $past(state_ff) == ST_FILL))
      else $error("result appeared outside hit or fill");
   a_grew_on_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_grew_ff) |-> !rsp_hit_ff)
      else $error("growth reported on a hit");
   a_victim_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WIN) |-> !first_ff)
      else $error("miss path entered without a victim candidate");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/algtc_tag_store.sv
// Tag and stamp memory with per-entry valid flags and registered read port.
`default_nettype none

module algtc_tag_store
   import algtc_pkg::*;
#(
   parameter int MaxEntries = MAX_ENTRIES_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire store_ctl_type                 ctl,
   input  wire logic [$clog2(MaxEntries)-1:0] rd_addr,
   input  wire logic [$clog2(MaxEntries)-1:0] wr_addr,
   input  wire row_type                       wr_data,
   output row_type                            rd_data,
   output logic                               rd_vld
);

   row_type                  mem [MaxEntries];
   logic [MaxEntries-1:0]    valid_ff;
   row_type                  rd_data_ff;
   logic                     rd_vld_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (ctl.rd_en) begin
            rd_vld_ff <= valid_ff[rd_addr];
         end
         if (ctl.clr_all) begin
            valid_ff <= ctl.wr_en ? (MaxEntries'(1) << wr_addr) : '0;
         end else if (ctl.wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   assign rd_data = rd_data_ff;
   assign rd_vld  = rd_vld_ff;

`ifndef SYNTH
   a_clr_then_one_valid: assert property (@(posedge clock) disable iff (reset)
      (ctl.clr_all && ctl.wr_en) |=> $onehot(valid_ff))
      else $error("invalidate with fill must leave one valid entry");
   a_clr_only: assert property (@(posedge clock) disable iff (reset)
      (ctl.clr_all && !ctl.wr_en) |=> (valid_ff == '0))
      else $error("invalidate left a valid entry");
   a_fill_sets_valid: assert property (@(posedge clock) disable iff (reset)
      ctl.wr_en |=> valid_ff[$past(wr_addr)])
      else $error("filled entry not marked valid");
`endif

endmodule

`default_nettype wire
